### design/front_insert_value_delete_list_macros.svh
// Assertion macros for the front insert / value delete list
`ifndef FRONT_INSERT_VALUE_DELETE_LIST_MACROS_SVH
`define FRONT_INSERT_VALUE_DELETE_LIST_MACROS_SVH

`ifndef SYNTHESIS
`define FIVDL_ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed: same-cycle implication");
`define FIVDL_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed: next-cycle implication");
`else
`define FIVDL_ASSERT_IMPLY(label, clk, rst_n, a, b)
`define FIVDL_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif

`endif

### design/fivdl_pkg.sv
// Shared types for the front insert / value delete list
`timescale 1ns / 1ps

package fivdl_pkg;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    typedef struct packed {
        logic load;
        logic exec;
    } ctrl_cmd_t;

endpackage

### design/fivdl_ctrl.sv
// Controller: transaction sequencing and output valid
`timescale 1ns / 1ps
`include "front_insert_value_delete_list_macros.svh"

module fivdl_ctrl
    import fivdl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  logic      out_stall,
    output ctrl_cmd_t cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd.load       = (state_reg == S_IDLE) && in_valid;
        cmd.exec       = (state_reg == S_EXEC) && (!out_valid_reg || !out_stall);
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.load)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (cmd.exec)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `FIVDL_ASSERT_NEXT(a_load_to_exec, clk, rst_n, cmd.load, state_reg == S_EXEC)
    `FIVDL_ASSERT_NEXT(a_exec_gives_result, clk, rst_n, cmd.exec, out_valid_reg)
    `FIVDL_ASSERT_NEXT(a_hold_while_blocked, clk, rst_n, (state_reg == S_EXEC) && out_valid_reg && out_stall, state_reg == S_EXEC)

endmodule

### design/fivdl_datapath.sv
// Datapath: entry cells, match compare, shift and result registers
`timescale 1ns / 1ps

module fivdl_datapath
    import fivdl_pkg::*;
#(
    parameter int CAPACITY  = 16,
    parameter int WORD_BITS = 32,
    parameter int CNT_BITS  = 5
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  ctrl_cmd_t            cmd,
    input  logic [1:0]           operation,
    input  logic [WORD_BITS-1:0] value,
    output logic [CNT_BITS-1:0]  entry_count,
    output logic                 is_full,
    output logic                 was_removed,
    output logic                 was_rejected
);

    localparam logic [CNT_BITS-1:0] CAP_CNT = CNT_BITS'(CAPACITY);

    op_t                  op_reg;
    logic [WORD_BITS-1:0] value_reg;
    logic [WORD_BITS-1:0] cell_reg [CAPACITY];
    logic [CNT_BITS-1:0]  count_reg;
    logic [CNT_BITS-1:0]  count_next;
    logic [CNT_BITS-1:0]  entry_count_reg;
    logic                 is_full_reg;
    logic                 was_removed_reg;
    logic                 was_rejected_reg;

    logic [CAPACITY-1:0]  match;
    logic [CAPACITY-1:0]  first_hit;
    logic [CAPACITY-1:0]  shift_mask;
    logic                 do_insert;
    logic                 do_delete;
    logic                 found;
    logic                 has_room;

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            match[i] = (CNT_BITS'(i) < count_reg) && (cell_reg[i] == value_reg);
        end
    end

    // lowest set bit marks the first match; cells at and past it take the word from the cell above
    assign first_hit  = match & (~match + CAPACITY'(1));
    assign shift_mask = ~(first_hit - CAPACITY'(1));
    assign found      = |match;
    assign has_room   = (count_reg < CAP_CNT);

    always_comb
    begin
        do_insert  = 1'b0;
        do_delete  = 1'b0;
        count_next = count_reg;
        unique case (op_reg)
            OP_INSERT:
            begin
                do_insert = has_room;
                if (has_room)
                begin
                    count_next = count_reg + CNT_BITS'(1);
                end
            end
            OP_DELETE:
            begin
                do_delete = found;
                if (found)
                begin
                    count_next = count_reg - CNT_BITS'(1);
                end
            end
            OP_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= op_t'(operation);
            value_reg <= value;
        end
        if (cmd.exec)
        begin
            entry_count_reg  <= count_next;
            is_full_reg      <= (count_next == CAP_CNT);
            was_removed_reg  <= do_delete;
            was_rejected_reg <= (op_reg == OP_INSERT) && !has_room;
        end
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [WORD_BITS-1:0] down_word;
        logic [WORD_BITS-1:0] up_word;

        if (i == 0)
        begin : g_front
            assign down_word = value_reg;
        end
        else
        begin : g_inner
            assign down_word = cell_reg[i-1];
        end

        if (i + 1 < CAPACITY)
        begin : g_up
            assign up_word = cell_reg[i+1];
        end
        else
        begin : g_last
            assign up_word = cell_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (cmd.exec && do_insert)
            begin
                cell_reg[i] <= down_word;
            end
            else if (cmd.exec && do_delete && shift_mask[i])
            begin
                cell_reg[i] <= up_word;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.exec)
        begin
            count_reg <= count_next;
        end
    end

    assign entry_count  = entry_count_reg;
    assign is_full      = is_full_reg;
    assign was_removed  = was_removed_reg;
    assign was_rejected = was_rejected_reg;

endmodule

### design/front_insert_value_delete_list.sv
// An accepted transaction is loaded, then executed; execute sets out_valid with the result.
// A new transaction is not accepted until the previous one has executed (load/execute);
// execute waits while a previous result is still held by out_stall.
// At execute, used cells are compared; insert shifts all, delete from the first match on.
// Reset clears the entry count and handshake state; entry cells are not reset.
`timescale 1ns / 1ps

module front_insert_value_delete_list
    import fivdl_pkg::*;
#(
    parameter int CAPACITY  = 16,
    parameter int WORD_BITS = 32
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          operation,
    input  logic signed [WORD_BITS-1:0]         value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [$clog2(CAPACITY+1)-1:0]       entry_count,
    output logic                                is_full,
    output logic                                was_removed,
    output logic                                was_rejected
);

    localparam int CNT_BITS = $clog2(CAPACITY + 1);

    ctrl_cmd_t cmd;

    fivdl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    fivdl_datapath #(
        .CAPACITY  (CAPACITY),
        .WORD_BITS (WORD_BITS),
        .CNT_BITS  (CNT_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .operation    (operation),
        .value        (value),
        .entry_count  (entry_count),
        .is_full      (is_full),
        .was_removed  (was_removed),
        .was_rejected (was_rejected)
    );

endmodule
